// File: src/rae_pkg.sv
// Shared types and constants of the register ALU instruction executor.
// Holds opcodes, pc step sizes, arithmetic unit commands and status records.
// No dependencies.
`default_nettype none

package rae_pkg;

   localparam int IDX_W  = 4;
   localparam int OP_W   = 4;
   localparam int WORD_W = 32;
   localparam int STEP_W = 3;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [OP_W-1:0]   op_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [STEP_W-1:0] step_type;

   // Instruction opcodes.
   localparam op_type OP_AND   = 4'd0;
   localparam op_type OP_OR    = 4'd1;
   localparam op_type OP_XOR   = 4'd2;
   localparam op_type OP_LOAD  = 4'd3;
   localparam op_type OP_ADD   = 4'd4;
   localparam op_type OP_SUB   = 4'd5;
   localparam op_type OP_MUL   = 4'd6;
   localparam op_type OP_DIV   = 4'd7;
   localparam op_type OP_PRINT = 4'd8;

   // Program counter increments.
   localparam step_type STEP_NONE   = 3'd0;
   localparam step_type STEP_BINARY = 3'd3;
   localparam step_type STEP_LOAD   = 3'd6;
   localparam step_type STEP_PRINT  = 3'd2;

   // Commands of the shared arithmetic unit.
   typedef logic [1:0] uop_type;
   localparam uop_type UOP_ADD = 2'd0;
   localparam uop_type UOP_SUB = 2'd1;
   localparam uop_type UOP_MUL = 2'd2;
   localparam uop_type UOP_DIV = 2'd3;

   typedef struct packed {
      logic    start;
      uop_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// File: src/rae_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on rae_pkg.
`default_nettype none

interface rae_req_if;
   import rae_pkg::*;

   logic               valid;
   logic               ready;
   op_type             operation;
   idx_type            dest_index;
   idx_type            source_index;
   logic signed [31:0] immediate;

   modport source (output valid, operation, dest_index, source_index, immediate,
                   input ready);
   modport sink   (input valid, operation, dest_index, source_index, immediate,
                   output ready);
endinterface

interface rae_rsp_if;
   import rae_pkg::*;

   logic               valid;
   logic               ready;
   logic [31:0]        next_pc;
   logic               print_valid;
   idx_type            print_index;
   logic signed [31:0] print_value;

   modport source (output valid, next_pc, print_valid, print_index, print_value,
                   input ready);
   modport sink   (input valid, next_pc, print_valid, print_index, print_value,
                   output ready);
endinterface

`default_nettype wire

// File: src/rae_regfile.sv
// Register file: a two-read, one-write memory with registered read data.
// Per-entry valid bits make never-written registers read as zero after reset.
// Depends on rae_pkg.
`default_nettype none

module rae_regfile #(
   parameter int NUM_REGS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  rae_pkg::idx_type   rd_idx_a,
   input  rae_pkg::idx_type   rd_idx_b,
   output rae_pkg::word_type  rd_data_a,
   output rae_pkg::word_type  rd_data_b,
   input  logic               wr_en,
   input  rae_pkg::idx_type   wr_idx,
   input  rae_pkg::word_type  wr_data
);
   import rae_pkg::*;

   localparam int AW = $clog2(NUM_REGS);
   localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

   word_type               mem [NUM_REGS];
   logic [NUM_REGS-1:0]    valid_ff;
   word_type               data_a_ff;
   word_type               data_b_ff;
   logic                   hit_a_ff;
   logic                   hit_b_ff;

   logic [XW-1:0] ra_wide;
   logic [XW-1:0] rb_wide;
   logic [XW-1:0] w_wide;
   logic          ra_ok;
   logic          rb_ok;
   logic          w_ok;
   logic [AW-1:0] ra_addr;
   logic [AW-1:0] rb_addr;
   logic [AW-1:0] w_addr;

   // Indexes at or above the register count read as zero and drop writes.
   assign ra_wide = XW'(rd_idx_a);
   assign rb_wide = XW'(rd_idx_b);
   assign w_wide  = XW'(wr_idx);
   assign ra_ok   = ra_wide < XW'(NUM_REGS);
   assign rb_ok   = rb_wide < XW'(NUM_REGS);
   assign w_ok    = w_wide < XW'(NUM_REGS);
   assign ra_addr = ra_wide[AW-1:0];
   assign rb_addr = rb_wide[AW-1:0];
   assign w_addr  = w_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en && w_ok) begin
         mem[w_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= mem[ra_addr];
         data_b_ff <= mem[rb_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         if (wr_en && w_ok) begin
            valid_ff[w_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_a_ff <= ra_ok && valid_ff[ra_addr];
            hit_b_ff <= rb_ok && valid_ff[rb_addr];
         end
      end
   end

   assign rd_data_a = hit_a_ff ? data_a_ff : '0;
   assign rd_data_b = hit_b_ff ? data_b_ff : '0;

endmodule

`default_nettype wire

// File: src/rae_arith.sv
// Shared arithmetic unit: one 34-bit adder/subtractor under a phase sequencer.
// Runs add and subtract in one step, multiply by shift-add and signed divide
// by restoring division, one bit per cycle. Depends on rae_pkg.
`default_nettype none

module rae_arith (
   input  logic                     clock,
   input  logic                     reset,
   input  rae_pkg::unit_cmd_type    cmd,
   input  rae_pkg::word_type        a_in,
   input  rae_pkg::word_type        b_in,
   output rae_pkg::unit_status_type status,
   output rae_pkg::word_type        result
);
   import rae_pkg::*;

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_ADD  = 3'd1;
   localparam logic [2:0] P_MUL  = 3'd2;
   localparam logic [2:0] P_NEGA = 3'd3;
   localparam logic [2:0] P_NEGB = 3'd4;
   localparam logic [2:0] P_DIV  = 3'd5;
   localparam logic [2:0] P_FIX  = 3'd6;
   localparam logic [2:0] P_DONE = 3'd7;

   localparam int SUM_W = WORD_W + 2;
   localparam int CNT_W = $clog2(WORD_W);

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   word_type         acc_ff, acc_in;
   word_type         q_ff, q_in;
   word_type         m_ff, m_in;
   logic             neg_ff, neg_in;
   logic             sub_ff, sub_in;

   logic [SUM_W-1:0] add_x;
   logic [SUM_W-1:0] add_y;
   logic             add_sub;
   logic [SUM_W-1:0] sum;

   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      unique case (phase_ff)
         P_ADD: begin
            add_x   = SUM_W'(q_ff);
            add_y   = SUM_W'(m_ff);
            add_sub = sub_ff;
         end
         P_MUL: begin
            add_x = SUM_W'(acc_ff);
            add_y = SUM_W'(m_ff);
         end
         P_NEGA, P_FIX: begin
            add_y   = SUM_W'(q_ff);
            add_sub = 1'b1;
         end
         P_NEGB: begin
            add_y   = SUM_W'(m_ff);
            add_sub = 1'b1;
         end
         P_DIV: begin
            // Partial remainder shifted left by one, less the divisor.
            add_x   = SUM_W'({acc_ff, q_ff[WORD_W-1]});
            add_y   = SUM_W'(m_ff);
            add_sub = 1'b1;
         end
         default: begin
         end
      endcase
      sum = add_x + (add_y ^ {SUM_W{add_sub}}) + SUM_W'(add_sub);
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      m_in     = m_ff;
      neg_in   = neg_ff;
      sub_in   = sub_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (cmd.start) begin
               q_in   = a_in;
               m_in   = b_in;
               acc_in = '0;
               cnt_in = '0;
               sub_in = (cmd.op == UOP_SUB);
               neg_in = a_in[WORD_W-1] ^ b_in[WORD_W-1];
               unique case (cmd.op)
                  UOP_ADD, UOP_SUB: phase_in = P_ADD;
                  UOP_MUL:          phase_in = P_MUL;
                  UOP_DIV:          phase_in = P_NEGA;
               endcase
            end
         end
         P_ADD: begin
            q_in     = sum[WORD_W-1:0];
            phase_in = P_DONE;
         end
         P_MUL: begin
            if (q_ff[0]) begin
               acc_in = sum[WORD_W-1:0];
            end
            q_in   = q_ff >> 1;
            m_in   = m_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            // The last step leaves the low product word where the result is read.
            if (cnt_ff == '1) begin
               q_in     = q_ff[0] ? sum[WORD_W-1:0] : acc_ff;
               phase_in = P_DONE;
            end
         end
         P_NEGA: begin
            if (q_ff[WORD_W-1]) begin
               q_in = sum[WORD_W-1:0];
            end
            phase_in = P_NEGB;
         end
         P_NEGB: begin
            if (m_ff[WORD_W-1]) begin
               m_in = sum[WORD_W-1:0];
            end
            phase_in = P_DIV;
         end
         P_DIV: begin
            // A clear top bit means the divisor fit and the quotient bit is one.
            if (!sum[SUM_W-1]) begin
               acc_in = sum[WORD_W-1:0];
               q_in   = {q_ff[WORD_W-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[WORD_W-2:0], q_ff[WORD_W-1]};
               q_in   = {q_ff[WORD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               phase_in = P_FIX;
            end
         end
         P_FIX: begin
            if (neg_ff) begin
               q_in = sum[WORD_W-1:0];
            end
            phase_in = P_DONE;
         end
         P_DONE: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
      m_ff   <= m_in;
      neg_ff <= neg_in;
      sub_ff <= sub_in;
   end

   assign status.idle = (phase_ff == P_IDLE);
   assign status.done = (phase_ff == P_DONE);
   assign result      = q_ff;

endmodule

`default_nettype wire

// File: src/register_alu_instruction_exec.sv
// Executes one decoded instruction per request beat against a file of NUM_REGS
// signed 32-bit registers and a 32-bit program counter, and returns one
// response beat per instruction with the new pc and, for print, the register
// index and value. The block takes one instruction at a time: AND, OR, XOR,
// load, print, an undefined opcode and a divide by zero finish without the
// arithmetic unit; ADD, SUB, MUL and DIV run in it, MUL and DIV longest, as
// the shared 34-bit adder there produces one multiplier or quotient
// bit per cycle. A finished response waits in an output register, so the next
// instruction is accepted while it is still unclaimed. Registers read as zero
// after reset through per-entry valid bits; there is no clearing pass.
// Depends on rae_pkg, rae_if, rae_regfile and rae_arith.
`default_nettype none

module register_alu_instruction_exec #(
   parameter int NUM_REGS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rae_req_if.sink   req_bus,
   rae_rsp_if.source rsp_bus
);
   import rae_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]      state_ff, state_in;
   op_type          op_ff, op_in;
   idx_type         dest_ff, dest_in;
   word_type        imm_ff, imm_in;
   word_type        res_ff, res_in;
   logic            wr_ff, wr_in;
   logic            print_ff, print_in;
   step_type        step_ff, step_in;
   word_type        pc_ff, pc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   word_type        rsp_pc_ff, rsp_pc_in;
   logic            rsp_print_ff, rsp_print_in;
   idx_type         rsp_index_ff, rsp_index_in;
   word_type        rsp_value_ff, rsp_value_in;

   logic            accept;
   logic            rf_wr_en;
   word_type        rf_a;
   word_type        rf_b;
   unit_cmd_type    unit_cmd;
   unit_status_type unit_status;
   word_type        unit_result;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   rae_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_idx_a  (req_bus.dest_index),
      .rd_idx_b  (req_bus.source_index),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b),
      .wr_en     (rf_wr_en),
      .wr_idx    (dest_ff),
      .wr_data   (res_ff)
   );

   rae_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .a_in   (rf_a),
      .b_in   (rf_b),
      .status (unit_status),
      .result (unit_result)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dest_in      = dest_ff;
      imm_in       = imm_ff;
      res_in       = res_ff;
      wr_in        = wr_ff;
      print_in     = print_ff;
      step_in      = step_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pc_in    = rsp_pc_ff;
      rsp_print_in = rsp_print_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rf_wr_en     = 1'b0;
      unit_cmd     = '{start: 1'b0, op: UOP_ADD};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_bus.operation;
               dest_in  = req_bus.dest_index;
               imm_in   = word_type'(req_bus.immediate);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // Operands arrive from the register file in this cycle.
            if (unit_status.idle) begin
               wr_in    = 1'b1;
               print_in = 1'b0;
               step_in  = STEP_BINARY;
               state_in = S_DONE;
               unique case (op_ff)
                  OP_AND: res_in = rf_a & rf_b;
                  OP_OR:  res_in = rf_a | rf_b;
                  OP_XOR: res_in = rf_a ^ rf_b;
                  OP_LOAD: begin
                     res_in  = imm_ff;
                     step_in = STEP_LOAD;
                  end
                  OP_ADD: begin
                     unit_cmd = '{start: 1'b1, op: UOP_ADD};
                     state_in = S_WAIT;
                  end
                  OP_SUB: begin
                     unit_cmd = '{start: 1'b1, op: UOP_SUB};
                     state_in = S_WAIT;
                  end
                  OP_MUL: begin
                     unit_cmd = '{start: 1'b1, op: UOP_MUL};
                     state_in = S_WAIT;
                  end
                  OP_DIV: begin
                     // A zero divisor leaves the destination untouched.
                     if (rf_b == '0) begin
                        wr_in = 1'b0;
                     end else begin
                        unit_cmd = '{start: 1'b1, op: UOP_DIV};
                        state_in = S_WAIT;
                     end
                  end
                  OP_PRINT: begin
                     wr_in    = 1'b0;
                     print_in = 1'b1;
                     res_in   = rf_a;
                     step_in  = STEP_PRINT;
                  end
                  default: begin
                     wr_in   = 1'b0;
                     step_in = STEP_NONE;
                  end
               endcase
            end
         end
         S_WAIT: begin
            if (unit_status.done) begin
               res_in   = unit_result;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rf_wr_en     = wr_ff;
               pc_in        = pc_ff + WORD_W'(step_ff);
               rsp_valid_in = 1'b1;
               rsp_pc_in    = pc_in;
               rsp_print_in = print_ff;
               rsp_index_in = print_ff ? dest_ff : '0;
               rsp_value_in = print_ff ? res_ff : '0;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dest_ff      <= dest_in;
      imm_ff       <= imm_in;
      res_ff       <= res_in;
      wr_ff        <= wr_in;
      print_ff     <= print_in;
      step_ff      <= step_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_print_ff <= rsp_print_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.next_pc     = rsp_pc_ff;
   assign rsp_bus.print_valid = rsp_print_ff;
   assign rsp_bus.print_index = rsp_index_ff;
   assign rsp_bus.print_value = $signed(rsp_value_ff);

endmodule

`default_nettype wire

// File: src/rae_checker.sv
// Port-level checks for the register ALU instruction executor.
// Bound to register_alu_instruction_exec; depends on rae_pkg and rae_if.
`default_nettype none

module rae_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [31:0]        rsp_next_pc,
   input logic               rsp_print_valid,
   input rae_pkg::idx_type   rsp_print_index,
   input logic signed [31:0] rsp_print_value
);
   import rae_pkg::*;

   // A stalled response beat stays up.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_next_pc) && $stable(rsp_print_valid)
                                  && $stable(rsp_print_index) && $stable(rsp_print_value))
      else $error("response payload changed while stalled");

   // Only print beats carry a register index and value.
   a_print_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_index == '0 && rsp_print_value == '0)
      else $error("print fields set on a non-print beat");

   // After taking an instruction the block is not ready in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("instruction accepted on back-to-back cycles");

endmodule

bind register_alu_instruction_exec rae_checker u_rae_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_next_pc     (rsp_bus.next_pc),
   .rsp_print_valid (rsp_bus.print_valid),
   .rsp_print_index (rsp_bus.print_index),
   .rsp_print_value (rsp_bus.print_value)
);

`default_nettype wire
